// ===== rtl/scfla_pkg.sv =====
package scfla_pkg;

    // Fixed field widths.
    localparam int SIZE_W     = 14;
    localparam int ADDR_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int UNIT_SHIFT = 3;
    localparam int UNIT_BYTES = 8;
    localparam int UNITS_W    = SIZE_W + 1 - UNIT_SHIFT;
    localparam int LINK_W     = ADDR_W + 1;
    localparam int BUMP_W     = ADDR_W + 1;
    localparam int ADDR_SPACE = 65536;

    // Request opcodes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FRESH     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] block_addr;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_addr;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic fin_direct;
        logic free_zero;
        logic pop;
        logic link;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic req_bad;
        logic req_free;
        logic head_valid;
        logic out_free;
    } t_ctrl_sts;

endpackage

// ===== rtl/scfla_ctrl.sv =====
module scfla_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  scfla_pkg::t_ctrl_sts  i_sts,
    output scfla_pkg::t_ctrl_cmd  o_cmd,
    output logic                  o_in_ready
);
    import scfla_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_POP    = 5'b01000,
        S_LINK   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // Bad sizes, fresh and exhausted allocations finish here.
                priority if (i_sts.req_bad || (!i_sts.req_free && !i_sts.head_valid)) begin
                    if (i_sts.out_free) begin
                        o_cmd.fin_direct = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.req_free) begin
                    o_cmd.free_zero = 1'b1;
                    n_state         = S_LINK;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_sts.out_free) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_LINK: begin
                if (i_sts.out_free) begin
                    o_cmd.link = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/scfla_datapath.sv =====
module scfla_datapath #(
    parameter int NUM_CLASSES = 1024,
    parameter int ARENA_UNITS = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  scfla_pkg::t_req       i_req,
    input  scfla_pkg::t_ctrl_cmd  i_cmd,
    output scfla_pkg::t_ctrl_sts  o_sts,
    input  logic                  i_ready,
    output logic                  o_valid,
    output scfla_pkg::t_rsp       o_rsp
);
    import scfla_pkg::*;

    localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int ARENA_END = (ARENA_UNITS > ADDR_SPACE) ? ADDR_SPACE : ARENA_UNITS;
    localparam logic [UNITS_W:0] MAX_UNITS = (UNITS_W + 1)'(NUM_CLASSES);
    localparam logic [BUMP_W:0]  END_X     = (BUMP_W + 1)'(ARENA_END);

    // Per-class head (valid + address), per-class tail, per-block next link.
    logic [LINK_W-1:0] r_head_mem [NUM_CLASSES];
    logic [ADDR_W-1:0] r_tail_mem [NUM_CLASSES];
    logic [LINK_W-1:0] r_link_mem [ADDR_SPACE];

    logic [LINK_W-1:0] r_head_rd;
    logic [ADDR_W-1:0] r_tail_rd;
    logic [LINK_W-1:0] r_link_rd;

    logic              r_cmd;
    logic              r_bad;
    logic [UNITS_W-1:0] r_units;
    logic [CLS_W-1:0]  r_cls;
    logic [ADDR_W-1:0] r_addr;

    logic [CLS_W-1:0]  r_clr_cnt;
    logic [BUMP_W-1:0] r_bump;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [SIZE_W:0]    sum_in;
    logic [UNITS_W-1:0] units_in;
    logic [CLS_W-1:0]   cls_in;
    logic               bad_in;
    logic [BUMP_W:0]    bump_sum;
    logic               fresh_ok;

    logic              head_we;
    logic [CLS_W-1:0]  head_wa;
    logic [LINK_W-1:0] head_wd;
    logic              link_we;
    logic [ADDR_W-1:0] link_wa;
    logic [LINK_W-1:0] link_wd;
    logic              out_load;
    t_rsp              out_d;

    // Round the byte size up to 8-byte units.
    assign sum_in   = {1'b0, i_req.size_bytes} + (SIZE_W + 1)'(UNIT_BYTES - 1);
    assign units_in = sum_in[SIZE_W:UNIT_SHIFT];
    assign cls_in   = CLS_W'(units_in - UNITS_W'(1));
    assign bad_in   = (units_in == '0) || ({1'b0, units_in} > MAX_UNITS);

    assign bump_sum = {1'b0, r_bump} + (BUMP_W + 1)'(r_units);
    assign fresh_ok = (bump_sum <= END_X);

    always_comb begin
        head_we = 1'b0;
        head_wa = r_cls;
        head_wd = '0;
        if (i_cmd.clear) begin
            head_we = 1'b1;
            head_wa = r_clr_cnt;
        end else if (i_cmd.pop) begin
            head_we = 1'b1;
            head_wd = r_link_rd;
        end else if (i_cmd.link && !r_head_rd[LINK_W-1]) begin
            head_we = 1'b1;
            head_wd = {1'b1, r_addr};
        end
    end

    // A freed block first gets an empty link, then the old tail points at it if the class list is not empty.
    always_comb begin
        link_we = 1'b0;
        link_wa = r_addr;
        link_wd = '0;
        if (i_cmd.free_zero) begin
            link_we = 1'b1;
        end else if (i_cmd.link && r_head_rd[LINK_W-1]) begin
            link_we = 1'b1;
            link_wa = r_tail_rd;
            link_wd = {1'b1, r_addr};
        end
    end

    always_comb begin
        out_load = i_cmd.fin_direct || i_cmd.pop || i_cmd.link;
        out_d    = '0;
        if (i_cmd.pop) begin
            out_d.result_addr = r_head_rd[ADDR_W-1:0];
            out_d.status      = ST_REUSED;
        end else if (i_cmd.link) begin
            out_d.status = ST_FREED;
        end else if (r_bad) begin
            out_d.status = ST_BAD_SIZE;
        end else if (fresh_ok) begin
            out_d.result_addr = r_bump[ADDR_W-1:0];
            out_d.status      = ST_FRESH;
        end else begin
            out_d.status = ST_EXHAUSTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_wa] <= head_wd;
        end
        if (i_cmd.link) begin
            r_tail_mem[r_cls] <= r_addr;
        end
        if (link_we) begin
            r_link_mem[link_wa] <= link_wd;
        end
        if (i_cmd.accept) begin
            r_head_rd <= r_head_mem[cls_in];
            r_tail_rd <= r_tail_mem[cls_in];
        end
        r_link_rd <= r_link_mem[r_head_rd[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd   <= i_req.cmd;
            r_bad   <= bad_in;
            r_units <= units_in;
            r_cls   <= cls_in;
            r_addr  <= i_req.block_addr;
        end
        if (out_load) begin
            r_out <= out_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_bump      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + CLS_W'(1);
            end
            if (i_cmd.fin_direct && !r_bad && fresh_ok) begin
                r_bump <= bump_sum[BUMP_W-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clear_last = (r_clr_cnt == CLS_W'(NUM_CLASSES - 1));
    assign o_sts.req_bad    = r_bad;
    assign o_sts.req_free   = (r_cmd == CMD_FREE);
    assign o_sts.head_valid = r_head_rd[LINK_W-1];
    assign o_sts.out_free   = !r_out_valid || i_ready;

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

// ===== rtl/size_class_free_list_allocator.sv =====
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_req (cmd, size_bytes, block_addr)
// response  out        o_valid / i_ready    o_rsp (result_addr, status)
//
// Bad size, fresh and exhausted allocations finish in the decide step; reuse and free
// go on to a pop or link step: after the registered head/tail read, reuse needs one
// more link memory read and free a second link memory write on the single write port.
// After reset a clearing pass empties the class heads before the first request is accepted.
// A held response does not block acceptance; the next item waits in its last
// step until the output register is free.
module size_class_free_list_allocator #(
    parameter int NUM_CLASSES = 1024,
    parameter int ARENA_UNITS = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  scfla_pkg::t_req i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output scfla_pkg::t_rsp o_rsp
);
    import scfla_pkg::*;

    localparam int ARENA_END = (ARENA_UNITS > ADDR_SPACE) ? ADDR_SPACE : ARENA_UNITS;

    t_ctrl_cmd ctrl_cmd;
    t_ctrl_sts ctrl_sts;

    scfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_sts      (ctrl_sts),
        .o_cmd      (ctrl_cmd),
        .o_in_ready (o_ready)
    );

    scfla_datapath #(
        .NUM_CLASSES (NUM_CLASSES),
        .ARENA_UNITS (ARENA_UNITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (ctrl_cmd),
        .o_sts   (ctrl_sts),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // The clearing pass must hold off requests right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("request accepted during head clearing pass");

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second request accepted while one is in flight");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.status <= ST_EXHAUSTED))
        else $error("undefined response status");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_REUSED && o_rsp.status != ST_FRESH)
            |-> (o_rsp.result_addr == '0))
        else $error("nonzero address on a response without a block");

    a_fresh_in_arena: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_FRESH)
            |-> ({1'b0, o_rsp.result_addr} < (ADDR_W + 1)'(ARENA_END)))
        else $error("fresh block outside the arena");

endmodule

// ===== dv/size_class_free_list_allocator_tb.sv =====
`timescale 1ns / 100ps

module size_class_free_list_allocator_tb;
    import scfla_pkg::*;

    localparam int NUM_CLASSES  = 1024;
    localparam int ARENA_UNITS  = 65536;
    localparam int ARENA_END    = (ARENA_UNITS > ADDR_SPACE) ? ADDR_SPACE : ARENA_UNITS;
    localparam int RANDOM_ITEMS = 730;
    localparam int SMALL_ITEMS  = 430;
    localparam int STALL_LIMIT  = 20000;
    localparam int SHOWN_ERRORS = 10;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_COIN} t_rx_mode;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_stim_row;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size_bytes;
    } t_held_block;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_req i_req;
    logic o_valid;
    logic i_ready;
    t_rsp o_rsp;

    // Shadow of the allocator state.
    logic [LINK_W-1:0] head_of [NUM_CLASSES];
    logic [ADDR_W-1:0] tail_of [NUM_CLASSES];
    logic [LINK_W-1:0] link_of [ADDR_SPACE];
    int unsigned       fresh_ptr;

    t_rsp        pending_rsps[$];
    t_held_block held_blocks[$];
    t_stim_row   directed_rows[$];

    int       burst_left;
    int       error_count;
    int       status_seen[5];
    int       items_sent;
    t_rsp     want_rsp;
    t_rx_mode rx_mode;
    int       rx_phase_left;
    int       rx_tick;
    int       idle_cycles;

    size_class_free_list_allocator #(
        .NUM_CLASSES(NUM_CLASSES),
        .ARENA_UNITS(ARENA_UNITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rsp  (o_rsp)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_rsp apply_request(t_req req);
        t_rsp        rsp;
        int unsigned units;
        int unsigned cls;
        rsp   = '0;
        units = (int'(req.size_bytes) + UNIT_BYTES - 1) / UNIT_BYTES;
        if (units == 0 || units > NUM_CLASSES) begin
            rsp.status = ST_BAD_SIZE;
        end else begin
            cls = units - 1;
            if (req.cmd == CMD_ALLOC) begin
                if (head_of[cls][ADDR_W]) begin
                    rsp.result_addr = head_of[cls][ADDR_W-1:0];
                    head_of[cls]    = link_of[rsp.result_addr];
                    rsp.status      = ST_REUSED;
                end else if (fresh_ptr + units <= ARENA_END) begin
                    rsp.result_addr = fresh_ptr[ADDR_W-1:0];
                    fresh_ptr       = fresh_ptr + units;
                    rsp.status      = ST_FRESH;
                end else begin
                    rsp.status = ST_EXHAUSTED;
                end
            end else begin
                link_of[req.block_addr] = '0;
                if (head_of[cls][ADDR_W]) begin
                    link_of[tail_of[cls]] = {1'b1, req.block_addr};
                end else begin
                    head_of[cls] = {1'b1, req.block_addr};
                end
                tail_of[cls] = req.block_addr;
                rsp.status   = ST_FREED;
            end
        end
        return rsp;
    endfunction

    // Mostly well-formed traffic: allocations, and frees of blocks handed out earlier.
    // The drain phase asks for large blocks so that the arena runs dry.
    function automatic t_req pick_request(bit drain_arena);
        t_req        req;
        int unsigned roll;
        int unsigned idx;
        int unsigned units;
        req.cmd        = CMD_ALLOC;
        req.block_addr = ADDR_W'($urandom);
        req.size_bytes = SIZE_W'($urandom_range(1, 128));
        roll           = $urandom_range(0, 99);
        if (roll < 4) begin
            req.cmd        = 1'($urandom);
            req.size_bytes = ($urandom_range(0, 1) == 0) ? '0 :
                             SIZE_W'($urandom_range(NUM_CLASSES * UNIT_BYTES + 1, 16383));
        end else if (roll < 8) begin
            // Foreign address, linked in as given.
            req.cmd        = CMD_FREE;
            req.size_bytes = SIZE_W'($urandom_range(1, NUM_CLASSES * UNIT_BYTES));
        end else if (roll < (drain_arena ? 25 : 50) && held_blocks.size() != 0) begin
            idx            = $urandom_range(0, held_blocks.size() - 1);
            units          = (int'(held_blocks[idx].size_bytes) + UNIT_BYTES - 1) / UNIT_BYTES;
            req.cmd        = CMD_FREE;
            req.block_addr = held_blocks[idx].addr;
            req.size_bytes = SIZE_W'((units - 1) * UNIT_BYTES + $urandom_range(1, UNIT_BYTES));
            held_blocks.delete(idx);
        end else if (drain_arena && roll < 90) begin
            req.size_bytes = SIZE_W'($urandom_range(6000, NUM_CLASSES * UNIT_BYTES));
        end else if (roll % 8 == 0) begin
            req.size_bytes = SIZE_W'($urandom_range(1, NUM_CLASSES * UNIT_BYTES));
        end
        return req;
    endfunction

    task automatic add_row(input logic cmd, input int size_bytes, input int block_addr,
                           input bit typed, input int want_addr, input logic [2:0] want_status);
        t_stim_row row;
        row.req.cmd             = cmd;
        row.req.size_bytes      = SIZE_W'(size_bytes);
        row.req.block_addr      = ADDR_W'(block_addr);
        row.typed               = typed;
        row.rsp.result_addr     = ADDR_W'(want_addr);
        row.rsp.status          = want_status;
        directed_rows.push_back(row);
    endtask

    // Drives one request, holds it until the transfer, then records what must come back.
    task automatic issue(input t_req req, input bit typed, input t_rsp typed_rsp);
        t_rsp rsp;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                       $urandom_range(1, 10);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (!o_ready);
        burst_left = burst_left - 1;
        items_sent = items_sent + 1;
        rsp = apply_request(req);
        pending_rsps.push_back(typed ? typed_rsp : rsp);
        if (req.cmd == CMD_ALLOC && (rsp.status == ST_REUSED || rsp.status == ST_FRESH)) begin
            held_blocks.push_back('{addr: rsp.result_addr, size_bytes: req.size_bytes});
        end
    endtask

    task automatic note_mismatch(input string what, input t_rsp want, input t_rsp got);
        if (error_count < SHOWN_ERRORS) begin
            $display("%0t: %s: expected addr %h status %0d, got addr %h status %0d",
                     $realtime, what, want.result_addr, want.status,
                     got.result_addr, got.status);
        end
        error_count = error_count + 1;
    endtask

    // Response checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (o_rsp.status < 5) begin
                status_seen[o_rsp.status] = status_seen[o_rsp.status] + 1;
            end
            if (pending_rsps.size() == 0) begin
                note_mismatch("response with none outstanding", '0, o_rsp);
            end else begin
                want_rsp = pending_rsps.pop_front();
                if (o_rsp.result_addr !== want_rsp.result_addr) begin
                    note_mismatch("result_addr differs", want_rsp, o_rsp);
                end
                if (o_rsp.status !== want_rsp.status) begin
                    note_mismatch("status differs", want_rsp, o_rsp);
                end
            end
        end
    end

    // The receiver switches at random between stall patterns.
    always @(posedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       <= t_rx_mode'($urandom_range(0, 3));
            rx_phase_left <= $urandom_range(20, 120);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: begin
                i_ready <= 1'b1;
            end
            RX_MOSTLY: begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
            RX_PERIODIC: begin
                i_ready <= (rx_tick % 5 > 1);
            end
            default: begin
                i_ready <= ($urandom_range(0, 1) == 1);
            end
        endcase
        rx_tick <= rx_tick + 1;
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
        end
        $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req         = '0;
        i_ready       = 1'b0;
        rx_mode       = RX_ALWAYS;
        rx_phase_left = 0;
        rx_tick       = 0;
        burst_left    = 0;
        error_count   = 0;
        items_sent    = 0;
        fresh_ptr     = 0;
        status_seen   = '{default: 0};
        foreach (head_of[k]) head_of[k] = '0;
        foreach (tail_of[k]) tail_of[k] = '0;
        foreach (link_of[k]) link_of[k] = '0;

        // Size edges and bad sizes on both commands.
        add_row(CMD_ALLOC, 0,     0,      1, 0, ST_BAD_SIZE);
        add_row(CMD_FREE,  0,     'hFFFF, 1, 0, ST_BAD_SIZE);
        add_row(CMD_ALLOC, 8193,  0,      1, 0, ST_BAD_SIZE);
        add_row(CMD_FREE,  16383, 'hAAAA, 1, 0, ST_BAD_SIZE);
        // Fresh space from the arena; the address field is ignored on allocate.
        add_row(CMD_ALLOC, 1,     'hFFFF, 1, 0, ST_FRESH);
        add_row(CMD_ALLOC, 8,     0,      0, 0, ST_FRESH);
        add_row(CMD_ALLOC, 9,     0,      0, 0, ST_FRESH);
        add_row(CMD_ALLOC, 8192,  0,      0, 0, ST_FRESH);
        // Two frees in the smallest class come back oldest first.
        add_row(CMD_FREE,  8,     0,      1, 0, ST_FREED);
        add_row(CMD_FREE,  1,     1,      1, 0, ST_FREED);
        add_row(CMD_ALLOC, 5,     0,      0, 0, ST_REUSED);
        add_row(CMD_ALLOC, 8,     0,      0, 0, ST_REUSED);
        add_row(CMD_ALLOC, 7,     0,      0, 0, ST_FRESH);
        // Largest class with the top address.
        add_row(CMD_FREE,  8192,  'hFFFF, 1, 0, ST_FREED);
        add_row(CMD_ALLOC, 8185,  0,      0, 0, ST_REUSED);
        // A double free goes unnoticed and hands the block out twice.
        add_row(CMD_FREE,  4000,  'h1234, 1, 0, ST_FREED);
        add_row(CMD_FREE,  4000,  'h1234, 1, 0, ST_FREED);
        add_row(CMD_ALLOC, 3993,  0,      0, 0, ST_REUSED);
        add_row(CMD_ALLOC, 4000,  0,      0, 0, ST_REUSED);
        add_row(CMD_ALLOC, 8185,  0,      0, 0, ST_FRESH);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            issue(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].rsp);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            issue(pick_request(n >= SMALL_ITEMS), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (pending_rsps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed), arena pointer ended at %0d of %0d units.",
                 items_sent, directed_rows.size(), fresh_ptr, ARENA_END);
        $display("Responses: %0d reused, %0d fresh, %0d freed, %0d bad size, %0d exhausted.",
                 status_seen[ST_REUSED], status_seen[ST_FRESH], status_seen[ST_FREED],
                 status_seen[ST_BAD_SIZE], status_seen[ST_EXHAUSTED]);
        if (error_count == 0 && pending_rsps.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
